// ----- src/pncs_pkg.sv -----
// shared types, constants and codes for the correspondence search block
// no dependencies
package pncs_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int COORD_BITS_DEF = 16;
    localparam int NORM_BITS      = 16;
    localparam int INDEX_BITS     = 10;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [31:0] RADIUS_SQ_RESET  = 32'd94372;
    localparam logic [30:0] MIN_COS_SQ_RESET = 31'd1073741781;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_RADIUS_SQ  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_COS_SQ = 1'b1;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_FULL     = 3'd1,
        ST_NO_MATCH = 3'd2,
        ST_DISAGREE = 3'd3,
        ST_MATCHED  = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]                     action;
        logic signed [COORD_BITS_DEF-1:0] pos_x;
        logic signed [COORD_BITS_DEF-1:0] pos_y;
        logic signed [NORM_BITS-1:0]    norm_x;
        logic signed [NORM_BITS-1:0]    norm_y;
    } in_item_t;

    typedef struct packed {
        logic [2:0]                     status;
        logic [INDEX_BITS-1:0]          match_index;
        logic signed [COORD_BITS_DEF-1:0] match_x;
        logic signed [COORD_BITS_DEF-1:0] match_y;
    } out_item_t;

endpackage

// ----- src/pncs_front.sv -----
// front end: input register stage, command queue of depth two
// depends on pncs_pkg
module pncs_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pncs_pkg::in_item_t in_item,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output pncs_pkg::in_item_t cmd_item
);

    pncs_pkg::in_item_t q_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         cnt_reg;
    logic               push;
    logic               pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd_item  = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push)
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd0 |-> !pop)
        else $error("queue underflow");
    a_count_move: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count lost a push");

endmodule

// ----- src/pncs_back.sv -----
// back end: reference memory, sequential nearest search, normal test
// depends on pncs_pkg
module pncs_back
#(
    parameter int MAX_POINTS = pncs_pkg::MAX_POINTS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [31:0]         radius_sq,
    input  logic [30:0]         min_cos_sq,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  pncs_pkg::in_item_t  cmd_item,
    output logic                out_valid,
    input  logic                out_ready,
    output pncs_pkg::out_item_t out_item
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_RD    = 10'b0000000010,
        S_DIFF  = 10'b0000000100,
        S_SQ    = 10'b0000001000,
        S_CMP   = 10'b0000010000,
        S_NRD   = 10'b0000100000,
        S_NDOT  = 10'b0001000000,
        S_NMUL  = 10'b0010000000,
        S_NADD  = 10'b0100000000,
        S_NFIN  = 10'b1000000000
    } state_t;

    state_t              state_reg;
    logic [63:0]         mem [MAX_POINTS];
    logic [63:0]         rd_data_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       scan_reg;
    logic [AW-1:0]       rd_addr;
    logic                rd_en;
    pncs_pkg::in_item_t  q_reg;
    logic signed [16:0]  dx_reg;
    logic signed [16:0]  dy_reg;
    logic signed [33:0]  dx_wide;
    logic signed [33:0]  dy_wide;
    logic [33:0]         dist_reg;
    logic [CW-1:0]       cand_reg;
    logic                found_reg;
    logic [AW-1:0]       best_reg;
    logic [33:0]         best_d_reg;
    logic signed [32:0]  dot_reg;
    logic [31:0]         dot_mag;
    logic [31:0]         q1_reg;
    logic [31:0]         q2_reg;
    logic [63:0]         d2_reg;
    logic [63:0]         q12_reg;
    logic [62:0]         prod_lo_reg;
    logic [62:0]         prod_hi_reg;
    logic [94:0]         rhs_reg;
    logic [93:0]         lhs;
    logic                out_valid_reg;
    pncs_pkg::out_item_t out_reg;
    pncs_pkg::out_item_t full_result;
    logic                sq_valid_reg;
    logic                diff_valid_reg;
    logic                rd_valid_reg;
    logic [33:0]         dist_next;
    logic                cmd_take;
    logic                scan_done;
    logic                result_load;
    logic signed [15:0]  rx;
    logic signed [15:0]  ry;
    logic signed [15:0]  rnx;
    logic signed [15:0]  rny;

    assign rx  = rd_data_reg[63:48];
    assign ry  = rd_data_reg[47:32];
    assign rnx = rd_data_reg[31:16];
    assign rny = rd_data_reg[15:0];

    assign cmd_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign cmd_take  = cmd_valid && cmd_ready;

    always_comb
    begin
        full_result        = '0;
        full_result.status = pncs_pkg::ST_FULL;
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = scan_reg[AW-1:0];
        if (state_reg == S_RD && scan_reg < count_reg)
        begin
            rd_en = 1'b1;
        end
        if (state_reg == S_NRD)
        begin
            rd_en   = 1'b1;
            rd_addr = best_reg;
        end
    end

    assign scan_done   = !rd_en && !rd_valid_reg && !diff_valid_reg && !sq_valid_reg;
    assign result_load = (cmd_take && cmd_item.action != pncs_pkg::ACT_QUERY)
                       || (state_reg == S_RD && scan_done && !found_reg)
                       || (state_reg == S_NFIN);

    always_ff @(posedge clk)
    begin
        if (cmd_take && cmd_item.action == pncs_pkg::ACT_APPEND
            && count_reg < CW'(MAX_POINTS))
        begin
            mem[count_reg[AW-1:0]] <= {cmd_item.pos_x, cmd_item.pos_y,
                                       cmd_item.norm_x, cmd_item.norm_y};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign dx_wide   = 34'(dx_reg);
    assign dy_wide   = 34'(dy_reg);
    assign dist_next = unsigned'(dx_wide * dx_wide) + unsigned'(dy_wide * dy_wide);
    assign dot_mag   = dot_reg[31:0];
    assign lhs       = {d2_reg, 30'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            scan_reg       <= '0;
            cand_reg       <= '0;
            found_reg      <= 1'b0;
            rd_valid_reg   <= 1'b0;
            diff_valid_reg <= 1'b0;
            sq_valid_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_take)
                    begin
                        q_reg     <= cmd_item;
                        scan_reg  <= '0;
                        found_reg <= 1'b0;
                        best_reg  <= '0;
                        case (cmd_item.action)
                            pncs_pkg::ACT_CLEAR:
                            begin
                                count_reg <= '0;
                                out_reg   <= '0;
                            end
                            pncs_pkg::ACT_APPEND:
                            begin
                                if (count_reg < CW'(MAX_POINTS))
                                begin
                                    count_reg <= count_reg + 1'b1;
                                    out_reg   <= '0;
                                end
                                else
                                begin
                                    out_reg <= full_result;
                                end
                            end
                            pncs_pkg::ACT_QUERY:
                            begin
                                out_reg   <= '0;
                                state_reg <= S_RD;
                            end
                            default:
                            begin
                                out_reg <= '0;
                            end
                        endcase
                    end
                end
                S_RD:
                begin
                    // pipelined scan: read, diff, square, compare
                    rd_valid_reg <= rd_en;
                    if (rd_en)
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                    diff_valid_reg <= rd_valid_reg;
                    dx_reg <= 17'(rx) - 17'(q_reg.pos_x);
                    dy_reg <= 17'(ry) - 17'(q_reg.pos_y);
                    sq_valid_reg <= diff_valid_reg;
                    dist_reg <= dist_next;
                    if (sq_valid_reg)
                    begin
                        if ({2'b0, radius_sq} > dist_reg
                            && (!found_reg || dist_reg < best_d_reg))
                        begin
                            found_reg  <= 1'b1;
                            best_reg   <= cand_reg[AW-1:0];
                            best_d_reg <= dist_reg;
                        end
                        cand_reg <= cand_reg + 1'b1;
                    end
                    if (scan_done)
                    begin
                        cand_reg <= '0;
                        if (found_reg)
                        begin
                            state_reg <= S_NRD;
                        end
                        else
                        begin
                            out_reg.status <= pncs_pkg::ST_NO_MATCH;
                            state_reg      <= S_IDLE;
                        end
                    end
                end
                S_NRD:
                begin
                    state_reg <= S_DIFF;
                end
                S_DIFF:
                begin
                    out_reg.match_index <= 10'(best_reg);
                    out_reg.match_x     <= rx;
                    out_reg.match_y     <= ry;
                    dot_reg <= 33'(q_reg.norm_x * rnx) + 33'(q_reg.norm_y * rny);
                    q1_reg  <= 32'(33'(q_reg.norm_x * q_reg.norm_x)
                                 + 33'(q_reg.norm_y * q_reg.norm_y));
                    q2_reg  <= 32'(33'(rnx * rnx) + 33'(rny * rny));
                    state_reg <= S_NDOT;
                end
                S_NDOT:
                begin
                    d2_reg    <= 64'(dot_mag) * 64'(dot_mag);
                    q12_reg   <= 64'(q1_reg) * 64'(q2_reg);
                    state_reg <= S_NMUL;
                end
                S_NMUL:
                begin
                    prod_lo_reg <= 63'(min_cos_sq) * 63'(q12_reg[31:0]);
                    prod_hi_reg <= 63'(min_cos_sq) * 63'(q12_reg[63:32]);
                    state_reg   <= S_NADD;
                end
                S_NADD:
                begin
                    rhs_reg   <= 95'(prod_lo_reg) + {prod_hi_reg, 32'd0};
                    state_reg <= S_NFIN;
                end
                S_NFIN:
                begin
                    if (dot_reg > 0 && {1'b0, lhs} > rhs_reg)
                    begin
                        out_reg.status <= pncs_pkg::ST_MATCHED;
                    end
                    else
                    begin
                        out_reg.status <= pncs_pkg::ST_DISAGREE;
                    end
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POINTS))
        else $error("count out of range");
    a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg)
        else $error("result dropped");
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RD |-> scan_reg <= count_reg)
        else $error("scan past count");

endmodule

// ----- src/point_normal_correspondence_search_core.sv -----
// Point to reference nearest-neighbor search with normal direction check.
// Channels: in (valid/ready, in_item_t) carries clear, append and query
// transfers; out (valid/ready, out_item_t) returns one result per item.
// Config writes via cfg_we/cfg_index/cfg_data while the block is idle.
// An input transfer is registered in the front queue before the back end
// takes it. For a query over count stored points, the back end makes one
// memory read per cycle through a four-stage distance pipe (read, diff,
// square, compare); when a neighbor is in range it follows with one read
// and five stages for the normal test, else the result is a no-match.
// Throughput: the back end holds one item at a time and takes the next in
// the cycle its result transfers, so clear and append run one per cycle
// while the receiver is ready, and a query holds it until its result loads.
// A two-deep queue in front keeps accepting meanwhile.
// Reset empties the table (count zero) and loads the default radius and
// cosine limit; the memory itself is not cleared, it is read only below
// the count. When the receiver stalls, the result register holds, the
// back end waits, and the front queue fills and then drops ready.
// depends on pncs_pkg, pncs_front, pncs_back
module point_normal_correspondence_search_core
#(
    parameter int MAX_POINTS = pncs_pkg::MAX_POINTS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  pncs_pkg::in_item_t                    in_item,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output pncs_pkg::out_item_t                   out_item,
    input  logic                                  cfg_we,
    input  logic [pncs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [pncs_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    logic [31:0]        radius_sq_reg;
    logic [30:0]        min_cos_sq_reg;
    logic               cmd_valid;
    logic               cmd_ready;
    pncs_pkg::in_item_t cmd_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_sq_reg  <= pncs_pkg::RADIUS_SQ_RESET;
            min_cos_sq_reg <= pncs_pkg::MIN_COS_SQ_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pncs_pkg::CFG_RADIUS_SQ:  radius_sq_reg  <= cfg_data;
                pncs_pkg::CFG_MIN_COS_SQ: min_cos_sq_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    pncs_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_item  (cmd_item)
    );

    pncs_back #(.MAX_POINTS(MAX_POINTS)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .radius_sq  (radius_sq_reg),
        .min_cos_sq (min_cos_sq_reg),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd_item   (cmd_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule

// ----- sim/tb_top.sv -----
// self-checking testbench for point_normal_correspondence_search_core
// drives clear, append and query transfers, predicts each result and checks it
// depends on pncs_pkg and the core with its submodules
module tb_top;

    localparam int TABLE_DEPTH = pncs_pkg::MAX_POINTS_DEF;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 40;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    pncs_pkg::in_item_t in_item;
    logic out_valid;
    logic out_ready;
    pncs_pkg::out_item_t out_item;
    logic cfg_we;
    logic [pncs_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [pncs_pkg::CFG_DATA_BITS-1:0] cfg_data;

    point_normal_correspondence_search_core #(.MAX_POINTS(TABLE_DEPTH)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic signed [15:0] tbl_px [TABLE_DEPTH];
    logic signed [15:0] tbl_py [TABLE_DEPTH];
    logic signed [15:0] tbl_nx [TABLE_DEPTH];
    logic signed [15:0] tbl_ny [TABLE_DEPTH];
    int tbl_count;
    logic [31:0] radius_lim;
    logic [30:0] cos_lim;

    pncs_pkg::out_item_t pending_results[$];
    int error_count;
    int item_count;
    int matched_count;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic bit normals_parallel(logic signed [15:0] ax, logic signed [15:0] ay,
                                            logic signed [15:0] bx, logic signed [15:0] by);
        logic signed [63:0] x1, y1, x2, y2, dot;
        logic [63:0] q1, q2;
        logic [127:0] lhs, rhs;
        x1 = ax; y1 = ay; x2 = bx; y2 = by;
        dot = x1 * x2 + y1 * y2;
        if (dot <= 0)
            return 1'b0;
        q1 = x1 * x1 + y1 * y1;
        q2 = x2 * x2 + y2 * y2;
        lhs = {64'd0, 64'(dot * dot)} << 30;
        rhs = {97'd0, cos_lim} * {64'd0, q1 * q2};
        return lhs > rhs;
    endfunction

    function automatic pncs_pkg::out_item_t search_result(pncs_pkg::in_item_t it);
        pncs_pkg::out_item_t r;
        logic signed [63:0] dx, dy;
        logic [63:0] d, best_d;
        bit found;
        int best;
        r = '0;
        found = 1'b0;
        best = 0;
        best_d = '0;
        case (pncs_pkg::action_t'(it.action))
            pncs_pkg::ACT_CLEAR: tbl_count = 0;
            pncs_pkg::ACT_APPEND:
            begin
                if (tbl_count >= TABLE_DEPTH)
                    r.status = pncs_pkg::ST_FULL;
                else
                begin
                    tbl_px[tbl_count] = it.pos_x;
                    tbl_py[tbl_count] = it.pos_y;
                    tbl_nx[tbl_count] = it.norm_x;
                    tbl_ny[tbl_count] = it.norm_y;
                    tbl_count++;
                end
            end
            pncs_pkg::ACT_QUERY:
            begin
                for (int j = 0; j < tbl_count; j++)
                begin
                    dx = tbl_px[j];
                    dx = dx - it.pos_x;
                    dy = tbl_py[j];
                    dy = dy - it.pos_y;
                    d = dx * dx + dy * dy;
                    if (d < {32'd0, radius_lim} && (!found || d < best_d))
                    begin
                        found = 1'b1;
                        best = j;
                        best_d = d;
                    end
                end
                if (!found)
                    r.status = pncs_pkg::ST_NO_MATCH;
                else
                begin
                    r.status = normals_parallel(it.norm_x, it.norm_y,
                                                tbl_nx[best], tbl_ny[best])
                               ? pncs_pkg::ST_MATCHED : pncs_pkg::ST_DISAGREE;
                    r.match_index = best[9:0];
                    r.match_x = tbl_px[best];
                    r.match_y = tbl_py[best];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_item(pncs_pkg::in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results = {pending_results, search_result(it)};
        if (it.action != pncs_pkg::ACT_NONE)
            item_count++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [pncs_pkg::CFG_INDEX_BITS-1:0] idx, logic [31:0] value);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == pncs_pkg::CFG_RADIUS_SQ)
            radius_lim = value;
        else
            cos_lim = value[30:0];
    endtask

    function automatic pncs_pkg::in_item_t make_item(pncs_pkg::action_t act, int px, int py,
                                                     int nx, int ny);
        pncs_pkg::in_item_t it;
        it.action = act;
        it.pos_x = px[15:0];
        it.pos_y = py[15:0];
        it.norm_x = nx[15:0];
        it.norm_y = ny[15:0];
        return it;
    endfunction

    function automatic int clamp16(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    task automatic test_directed();
        send_item(make_item(pncs_pkg::ACT_CLEAR, 0, 0, 0, 0));
        send_item(make_item(pncs_pkg::ACT_QUERY, 0, 0, 16384, 0));
        send_item(make_item(pncs_pkg::ACT_APPEND, 32767, 32767, 16384, 0));
        send_item(make_item(pncs_pkg::ACT_APPEND, -32768, -32768, -32768, -32768));
        send_item(make_item(pncs_pkg::ACT_APPEND, 100, 100, 0, 16384));
        send_item(make_item(pncs_pkg::ACT_APPEND, 100, 100, 0, 16384));
        send_item(make_item(pncs_pkg::ACT_QUERY, 32767, 32767, 16384, 0));
        send_item(make_item(pncs_pkg::ACT_QUERY, -32768, -32768, -32768, -32768));
        send_item(make_item(pncs_pkg::ACT_QUERY, -32768, -32768, 32767, 32767));
        // tie goes to the lower index
        send_item(make_item(pncs_pkg::ACT_QUERY, 110, 90, 0, 16384));
        // zero normal never agrees
        send_item(make_item(pncs_pkg::ACT_QUERY, 100, 100, 0, 0));
        send_item(make_item(pncs_pkg::ACT_QUERY, 100, 100, 0, -16384));
        send_item(make_item(pncs_pkg::ACT_QUERY, 100, 100, 1, 16384));
        send_item(make_item(pncs_pkg::ACT_QUERY, 0, 0, 0, 16384));
        send_item(make_item(pncs_pkg::ACT_QUERY, 407, 100, 0, 16384));
        send_item(make_item(pncs_pkg::ACT_NONE, -1, -1, -1, -1));
        send_item(make_item(pncs_pkg::ACT_QUERY, 100, 100, 0, 32767));
        send_item(make_item(pncs_pkg::ACT_CLEAR, -1, -1, -1, -1));
        send_item(make_item(pncs_pkg::ACT_QUERY, 100, 100, 0, 16384));
    endtask

    task automatic test_random(int n);
        int sent, k, j, cx, cy, nx, ny;
        int lpx[16], lpy[16], lnx[16], lny[16];
        sent = 0;
        while (sent < n)
        begin
            cx = $signed(16'($urandom));
            cy = $signed(16'($urandom));
            k = $urandom_range(1, 12);
            send_item(make_item(pncs_pkg::ACT_CLEAR, cx, cy, $urandom, $urandom));
            sent++;
            for (int i = 0; i < k; i++)
            begin
                lpx[i] = clamp16(cx + $signed(11'($urandom)));
                lpy[i] = clamp16(cy + $signed(11'($urandom)));
                lnx[i] = $signed(16'($urandom));
                lny[i] = $signed(16'($urandom));
                send_item(make_item(pncs_pkg::ACT_APPEND, lpx[i], lpy[i], lnx[i], lny[i]));
                sent++;
            end
            for (int q = $urandom_range(1, 8); q > 0; q--)
            begin
                j = $urandom_range(k - 1);
                case ($urandom_range(5))
                    0, 1: begin nx = lnx[j]; ny = lny[j]; end
                    2: begin nx = clamp16(lnx[j] + $signed(2'($urandom)));
                             ny = lny[j]; end
                    3: begin nx = clamp16(-lnx[j]); ny = clamp16(-lny[j]); end
                    default: begin nx = $signed(16'($urandom)); ny = $signed(16'($urandom)); end
                endcase
                if ($urandom_range(6) == 0)
                    send_item(make_item(pncs_pkg::action_t'($urandom_range(3)),
                                        $urandom, $urandom, $urandom, $urandom));
                else
                    send_item(make_item(pncs_pkg::ACT_QUERY,
                                        clamp16(lpx[j] + $signed(9'($urandom))),
                                        clamp16(lpy[j] + $signed(9'($urandom))), nx, ny));
                sent++;
            end
        end
    endtask

    task automatic report_field(string name, int expv, int actv);
        $display("%0t mismatch %s expected %0d actual %0d", $time, name, expv, actv);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        pncs_pkg::out_item_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t unexpected result status %0d", $time, out_item.status);
                    error_count++;
                end
                else
                begin
                    e = pending_results.pop_front();
                    if (e.status == pncs_pkg::ST_MATCHED)
                        matched_count++;
                    if (e.status !== out_item.status)
                        report_field("status", e.status, out_item.status);
                    if (e.match_index !== out_item.match_index)
                        report_field("match_index", e.match_index, out_item.match_index);
                    if (e.match_x !== out_item.match_x)
                        report_field("match_x", e.match_x, out_item.match_x);
                    if (e.match_y !== out_item.match_y)
                        report_field("match_y", e.match_y, out_item.match_y);
                end
            end
            if ((out_valid && out_ready) || (in_valid && in_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t timeout, %0d results outstanding", $time,
                         pending_results.size());
                $display("FAIL");
                $finish;
            end
        end
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        item_count = 0;
        matched_count = 0;
        quiet_cycles = 0;
        tbl_count = 0;
        radius_lim = pncs_pkg::RADIUS_SQ_RESET;
        cos_lim = pncs_pkg::MIN_COS_SQ_RESET;
        send_idle_pct = 30;
        recv_idle_pct = 53;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        write_reg(pncs_pkg::CFG_RADIUS_SQ, $urandom_range(20000, 2000000));
        test_random(95);
        write_reg(pncs_pkg::CFG_MIN_COS_SQ, 0);
        test_random(95);

        send_idle_pct = 53;
        recv_idle_pct = 30;
        write_reg(pncs_pkg::CFG_RADIUS_SQ, 32'hFFFF_FFFF);
        write_reg(pncs_pkg::CFG_MIN_COS_SQ, 31'h4000_0000);
        test_random(95);
        write_reg(pncs_pkg::CFG_RADIUS_SQ, 0);
        test_random(40);
        write_reg(pncs_pkg::CFG_MIN_COS_SQ, $urandom_range(31'h4000_0000));
        write_reg(pncs_pkg::CFG_RADIUS_SQ, $urandom);
        test_random(55);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(pncs_pkg::CFG_RADIUS_SQ, pncs_pkg::RADIUS_SQ_RESET);
        write_reg(pncs_pkg::CFG_MIN_COS_SQ, pncs_pkg::MIN_COS_SQ_RESET);
        test_random(95);
        write_reg(pncs_pkg::CFG_RADIUS_SQ, $urandom_range(20000, 2000000));
        test_random(95);

        wait_idle();
        $display("covered %0d transfers, %0d matched", item_count, matched_count);
        $display("across idle patterns and radius/cosine extremes");
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ----- files.f -----
src/pncs_pkg.sv
src/pncs_front.sv
src/pncs_back.sv
src/point_normal_correspondence_search_core.sv
sim/tb_top.sv
